// ===== rtl/assert_macros.svh =====
// Assertion macros used by the alarm clock core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/alclk_pkg.sv =====
// Types, codes, constants and lookup functions of the alarm clock.
package alclk_pkg;

  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_DISMISS = 2'd1;
  localparam logic [1:0] FUNC_SET     = 2'd2;

  localparam logic [1:0] REG_ALARM_HOUR      = 2'd0;
  localparam logic [1:0] REG_ALARM_MINUTE    = 2'd1;
  localparam logic [1:0] REG_ALARM_INDICATOR = 2'd2;

  localparam logic [5:0] SEC_MAX  = 6'd59;
  localparam logic [5:0] MIN_MAX  = 6'd59;
  localparam logic [4:0] HOUR_MAX = 5'd23;

  localparam logic [14:0] DOT_BIT    = 15'h4000;
  localparam logic [14:0] BLANK_WORD = 15'h0000;
  localparam logic [11:0] PULSE_MAX  = 12'd2300;

  // Reciprocals of 59 scaled by 2^16 and folded with the dial spans
  // (2300-495 and 2300-526), rounded up; exact for counts up to 59.
  localparam logic [20:0] MIN_RECIP = 21'd2004958;
  localparam logic [20:0] SEC_RECIP = 21'd1970524;

  typedef struct packed {
    logic [5:0] second_count;
    logic [5:0] minute_count;
    logic [4:0] hour_count;
    logic       ringing;
    logic       flash_phase;
  } clk_state_t;

  typedef struct packed {
    logic [14:0] digit_hour_tens;
    logic [14:0] digit_hour_units;
    logic [14:0] digit_minute_tens;
    logic [14:0] digit_minute_units;
    logic [11:0] minute_pulse_us;
    logic [11:0] second_pulse_us;
    logic        alarm_led;
    logic        alarm_active;
  } result_t;

  function automatic logic [14:0] seg_word(input logic [3:0] digit);
    logic [14:0] w;
    case (digit)
      4'd0: w = 15'h0C3F;
      4'd1: w = 15'h0006;
      4'd2: w = 15'h00DB;
      4'd3: w = 15'h008F;
      4'd4: w = 15'h00E6;
      4'd5: w = 15'h2069;
      4'd6: w = 15'h00FD;
      4'd7: w = 15'h0007;
      4'd8: w = 15'h00FF;
      4'd9: w = 15'h00EF;
      default: w = BLANK_WORD;
    endcase
    return w;
  endfunction

  // 2300 minus floor(span * count / 59), via the scaled reciprocal.
  function automatic logic [11:0] dial_pulse(input logic [5:0] count,
                                             input logic [20:0] recip);
    logic [26:0] prod;
    prod = 27'(count) * 27'(recip);
    return PULSE_MAX - {1'b0, prod[26:16]};
  endfunction

endpackage

// ===== rtl/alclk_in_if.sv =====
// Input channel of the alarm clock: one event per beat.
interface alclk_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [4:0] set_hour;
  logic [5:0] set_minute;

  modport source (output valid, output func, output set_hour, output set_minute,
                  input ready);
  modport sink (input valid, input func, input set_hour, input set_minute,
                output ready);
endinterface

// ===== rtl/alclk_out_if.sv =====
// Output channel of the alarm clock: display words, dial pulses and LED per beat.
interface alclk_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] digit_hour_tens;
  logic [14:0] digit_hour_units;
  logic [14:0] digit_minute_tens;
  logic [14:0] digit_minute_units;
  logic [11:0] minute_pulse_us;
  logic [11:0] second_pulse_us;
  logic        alarm_led;
  logic        alarm_active;

  modport source (output valid, output digit_hour_tens, output digit_hour_units,
                  output digit_minute_tens, output digit_minute_units,
                  output minute_pulse_us, output second_pulse_us,
                  output alarm_led, output alarm_active, input ready);
  modport sink (input valid, input digit_hour_tens, input digit_hour_units,
                input digit_minute_tens, input digit_minute_units,
                input minute_pulse_us, input second_pulse_us,
                input alarm_led, input alarm_active, output ready);
endinterface

// ===== rtl/alclk_core.sv =====
// Timekeeping state: seconds, minutes, hours, alarm ringing and flash phase.
`include "assert_macros.svh"

module alclk_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [1:0]            func,
  input  logic [4:0]            set_hour,
  input  logic [5:0]            set_minute,
  input  logic [4:0]            alarm_hour,
  input  logic [5:0]            alarm_minute,
  output alclk_pkg::clk_state_t state_next
);

  alclk_pkg::clk_state_t state;

  always_comb begin
    state_next = state;
    if (step) begin
      case (func)
        alclk_pkg::FUNC_TICK: begin
          if (state.second_count >= alclk_pkg::SEC_MAX) begin
            state_next.second_count = '0;
            if (state.minute_count >= alclk_pkg::MIN_MAX) begin
              state_next.minute_count = '0;
              state_next.hour_count = (state.hour_count >= alclk_pkg::HOUR_MAX) ?
                                      5'd0 : state.hour_count + 5'd1;
            end else begin
              state_next.minute_count = state.minute_count + 6'd1;
            end
            if (state_next.hour_count == alarm_hour &&
                state_next.minute_count == alarm_minute) begin
              state_next.ringing = 1'b1;
            end
          end else begin
            state_next.second_count = state.second_count + 6'd1;
          end
          // A match on this very tick already starts the flashing.
          if (state_next.ringing) begin
            state_next.flash_phase = ~state.flash_phase;
          end
        end
        alclk_pkg::FUNC_DISMISS: begin
          state_next.ringing = 1'b0;
          state_next.flash_phase = 1'b0;
        end
        alclk_pkg::FUNC_SET: begin
          state_next.hour_count = (set_hour > alclk_pkg::HOUR_MAX) ?
                                  alclk_pkg::HOUR_MAX : set_hour;
          state_next.minute_count = (set_minute > alclk_pkg::MIN_MAX) ?
                                    alclk_pkg::MIN_MAX : set_minute;
        end
        default: begin
          state_next = state;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else begin
      state <= state_next;
    end
  end

  `ASSERT_IMPLIES(a_time_range, clk, rst, 1'b1,
                  state.second_count <= alclk_pkg::SEC_MAX &&
                  state.minute_count <= alclk_pkg::MIN_MAX &&
                  state.hour_count <= alclk_pkg::HOUR_MAX)
  `ASSERT_NEXT(a_dismiss_clears, clk, rst,
               step && func == alclk_pkg::FUNC_DISMISS,
               !state.ringing && !state.flash_phase)
  `ASSERT_IMPLIES(a_flash_needs_ring, clk, rst, !state.ringing, !state.flash_phase)

endmodule

// ===== rtl/alclk_disp.sv =====
// Display and dial encoding of one clock state into a result word set.
module alclk_disp (
  input  logic                  alarm_indicator,
  input  alclk_pkg::clk_state_t state,
  output alclk_pkg::result_t    res
);

  logic        pm;
  logic [3:0]  disp_hour;
  logic [3:0]  hour_units;
  logic [9:0]  tens_prod;
  logic [2:0]  min_tens;
  logic [5:0]  min_units;

  always_comb begin
    pm = (state.hour_count >= 5'd12);
    if (state.hour_count == 5'd0) begin
      disp_hour = 4'd12;
    end else if (state.hour_count > 5'd12) begin
      disp_hour = 4'(state.hour_count - 5'd12);
    end else begin
      disp_hour = state.hour_count[3:0];
    end
    hour_units = (disp_hour >= 4'd10) ? disp_hour - 4'd10 : disp_hour;

    // Divide by ten as multiply by 13/128, exact below 69.
    tens_prod = 10'(state.minute_count) * 10'd13;
    min_tens  = tens_prod[9:7];
    min_units = state.minute_count - 6'(min_tens) * 6'd10;

    res.digit_hour_tens = ((disp_hour >= 4'd10) ? alclk_pkg::seg_word(4'd1) :
                           alclk_pkg::BLANK_WORD) |
                          (pm ? alclk_pkg::DOT_BIT : alclk_pkg::BLANK_WORD);
    res.digit_hour_units   = alclk_pkg::seg_word(hour_units);
    res.digit_minute_tens  = alclk_pkg::seg_word({1'b0, min_tens});
    res.digit_minute_units = alclk_pkg::seg_word(min_units[3:0]) |
                             (alarm_indicator ? alclk_pkg::DOT_BIT :
                              alclk_pkg::BLANK_WORD);
    res.minute_pulse_us = alclk_pkg::dial_pulse(state.minute_count, alclk_pkg::MIN_RECIP);
    res.second_pulse_us = alclk_pkg::dial_pulse(state.second_count, alclk_pkg::SEC_RECIP);
    res.alarm_led    = state.flash_phase;
    res.alarm_active = state.ringing;
  end

endmodule

// ===== rtl/alarm_clock_with_display_and_dials.sv =====
// Top level of the 24-hour alarm clock with display words, servo dials and LED.
//
// Usage:
//   in_ch carries one event per beat: func 0 is a one-second tick, 1 dismisses
//   the alarm, 2 loads hour and minute (saturated). Code 3 changes nothing.
//   out_ch returns exactly one result beat per event, showing the state after
//   that event: four 14-segment words in 12-hour form, the minute and second
//   servo pulse widths in microseconds, the LED phase and the ringing flag.
//   The alarm registers are written through cfg_we/cfg_index/cfg_data, by the user
//   only while no event is in flight (not enforced by the block); index 3 is ignored.
// Timing:
//   An event is registered in the input stage on acceptance; when the output
//   stage advances, the clock state is updated and the result register loaded,
//   and the result is then valid. One event per cycle is sustained while
//   out_ch.ready is high; the state update and encoding are combinational.
// Reset and stalls:
//   Synchronous reset clears time, alarm state and registers to zero and
//   empties both stages. While out_ch.ready is low the result register holds,
//   the input stage fills, and in_ch.ready drops only once both are full.
module alarm_clock_with_display_and_dials (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [5:0]        cfg_data,
  alclk_in_if.sink          in_ch,
  alclk_out_if.source       out_ch
);

  logic [4:0] alarm_hour;
  logic [5:0] alarm_minute;
  logic       alarm_indicator;

  logic       s1_vld;
  logic [1:0] s1_func;
  logic [4:0] s1_hour;
  logic [5:0] s1_minute;

  logic                  out_vld;
  alclk_pkg::result_t    out_res;
  alclk_pkg::result_t    res_next;
  alclk_pkg::clk_state_t state_next;

  logic advance;
  logic step;

  assign advance     = !out_vld || out_ch.ready;
  assign step        = s1_vld && advance;
  assign in_ch.ready = !s1_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_hour      <= '0;
      alarm_minute    <= '0;
      alarm_indicator <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        alclk_pkg::REG_ALARM_HOUR:      alarm_hour      <= cfg_data[4:0];
        alclk_pkg::REG_ALARM_MINUTE:    alarm_minute    <= cfg_data;
        alclk_pkg::REG_ALARM_INDICATOR: alarm_indicator <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (in_ch.ready) begin
      s1_vld <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_func   <= in_ch.func;
      s1_hour   <= in_ch.set_hour;
      s1_minute <= in_ch.set_minute;
    end
  end

  alclk_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .func         (s1_func),
    .set_hour     (s1_hour),
    .set_minute   (s1_minute),
    .alarm_hour   (alarm_hour),
    .alarm_minute (alarm_minute),
    .state_next   (state_next)
  );

  alclk_disp u_disp (
    .alarm_indicator (alarm_indicator),
    .state           (state_next),
    .res             (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res_next;
    end
  end

  assign out_ch.valid              = out_vld;
  assign out_ch.digit_hour_tens    = out_res.digit_hour_tens;
  assign out_ch.digit_hour_units   = out_res.digit_hour_units;
  assign out_ch.digit_minute_tens  = out_res.digit_minute_tens;
  assign out_ch.digit_minute_units = out_res.digit_minute_units;
  assign out_ch.minute_pulse_us    = out_res.minute_pulse_us;
  assign out_ch.second_pulse_us    = out_res.second_pulse_us;
  assign out_ch.alarm_led          = out_res.alarm_led;
  assign out_ch.alarm_active       = out_res.alarm_active;

endmodule
